FILE: src/psev_pkg.sv
`timescale 1ns / 1ps

package psev_pkg;

   // Operand width of the stack and of the arithmetic unit.
   localparam int DATA_W = 32;
   // Bit counter width for one pass over an operand.
   localparam int CNT_W = $clog2(DATA_W);

   // Stream payload widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // Operator codes.
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_REM = 3'd4;
   localparam logic [2:0] OP_POW = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;
   localparam logic [1:0] ST_DIVZ  = 2'd3;

   typedef struct packed {
      logic       start;
      logic [2:0] op;
   } alu_ctl_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

FILE: src/psev_ram.sv
`timescale 1ns / 1ps

module psev_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/psev_alu.sv
`timescale 1ns / 1ps

// Iterative arithmetic unit: one bit of an operand is handled per cycle.
module psev_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  psev_pkg::alu_ctl_type       ctl,
   input  logic [psev_pkg::DATA_W-1:0] a,
   input  logic [psev_pkg::DATA_W-1:0] b,
   output psev_pkg::alu_rsp_type       rsp
);

   localparam int W = psev_pkg::DATA_W;
   localparam int CW = psev_pkg::CNT_W;
   localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

   typedef enum logic [8:0] {
      A_IDLE = 9'b000000001,
      A_ADD  = 9'b000000010,
      A_MUL  = 9'b000000100,
      A_DIV  = 9'b000001000,
      A_FIX  = 9'b000010000,
      A_PCHK = 9'b000100000,
      A_PMUL = 9'b001000000,
      A_PSQ  = 9'b010000000,
      A_DONE = 9'b100000000
   } alu_state_type;

   alu_state_type state_ff, state_in;
   logic [W-1:0]  mx_ff, mx_in;
   logic [W-1:0]  my_ff, my_in;
   logic [W-1:0]  mp_ff, mp_in;
   logic [W-1:0]  pacc_ff, pacc_in;
   logic [W-1:0]  psq_ff, psq_in;
   logic [W-1:0]  pex_ff, pex_in;
   logic [W-1:0]  res_ff, res_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          cy_ff, cy_in;
   logic          neg_ff, neg_in;
   logic          rsel_ff, rsel_in;

   logic [W-1:0] mp_step;
   logic         sum_bit;
   logic         sum_cy;
   logic [W:0]   div_sh;
   logic [W:0]   div_diff;
   logic [W-1:0] fix_val;
   logic [W-1:0] pex_sh;
   logic         last_step;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? (W'(0) - v) : v;
   endfunction

   always_comb begin
      mp_step   = my_ff[0] ? (mp_ff + mx_ff) : mp_ff;
      sum_bit   = mx_ff[0] ^ my_ff[0] ^ cy_ff;
      sum_cy    = (mx_ff[0] & my_ff[0]) | (cy_ff & (mx_ff[0] ^ my_ff[0]));
      div_sh    = {mp_ff, my_ff[W-1]};
      div_diff  = div_sh - {1'b0, mx_ff};
      fix_val   = rsel_ff ? mp_ff : my_ff;
      pex_sh    = pex_ff >> 1;
      last_step = (cnt_ff == CNT_LAST);

      state_in = state_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      mp_in    = mp_ff;
      pacc_in  = pacc_ff;
      psq_in   = psq_ff;
      pex_in   = pex_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      cy_in    = cy_ff;
      neg_in   = neg_ff;
      rsel_in  = rsel_ff;

      case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               cnt_in = '0;
               mp_in  = '0;
               case (ctl.op)
                  psev_pkg::OP_ADD, psev_pkg::OP_SUB: begin
                     mx_in    = b;
                     my_in    = (ctl.op == psev_pkg::OP_SUB) ? ~a : a;
                     cy_in    = (ctl.op == psev_pkg::OP_SUB);
                     state_in = A_ADD;
                  end
                  psev_pkg::OP_MUL: begin
                     mx_in    = b;
                     my_in    = a;
                     state_in = A_MUL;
                  end
                  psev_pkg::OP_DIV, psev_pkg::OP_REM: begin
                     mx_in    = mag(a);
                     my_in    = mag(b);
                     rsel_in  = (ctl.op == psev_pkg::OP_REM);
                     neg_in   = (ctl.op == psev_pkg::OP_REM) ? b[W-1] : (a[W-1] ^ b[W-1]);
                     state_in = A_DIV;
                  end
                  psev_pkg::OP_POW: begin
                     if (a[W-1]) begin
                        // Negative exponent: only unit bases survive.
                        if (b == W'(1)) begin
                           res_in = W'(1);
                        end else if (b == {W{1'b1}}) begin
                           res_in = a[0] ? {W{1'b1}} : W'(1);
                        end else begin
                           res_in = '0;
                        end
                        state_in = A_DONE;
                     end else begin
                        pacc_in  = W'(1);
                        psq_in   = b;
                        pex_in   = a;
                        state_in = A_PCHK;
                     end
                  end
                  default: begin
                     res_in   = '0;
                     state_in = A_DONE;
                  end
               endcase
            end
         end
         A_ADD: begin
            mx_in  = mx_ff >> 1;
            my_in  = my_ff >> 1;
            cy_in  = sum_cy;
            mp_in  = {sum_bit, mp_ff[W-1:1]};
            cnt_in = cnt_ff + CW'(1);
            if (last_step) begin
               res_in   = {sum_bit, mp_ff[W-1:1]};
               state_in = A_DONE;
            end
         end
         A_MUL, A_PMUL, A_PSQ: begin
            mp_in  = mp_step;
            mx_in  = mx_ff << 1;
            my_in  = my_ff >> 1;
            cnt_in = cnt_ff + CW'(1);
            if (last_step) begin
               if (state_ff == A_MUL) begin
                  res_in   = mp_step;
                  state_in = A_DONE;
               end else if (state_ff == A_PSQ) begin
                  psq_in   = mp_step;
                  state_in = A_PCHK;
               end else begin
                  pacc_in = mp_step;
                  pex_in  = pex_sh;
                  if (pex_sh == '0) begin
                     res_in   = mp_step;
                     state_in = A_DONE;
                  end else begin
                     mx_in    = psq_ff;
                     my_in    = psq_ff;
                     mp_in    = '0;
                     cnt_in   = '0;
                     state_in = A_PSQ;
                  end
               end
            end
         end
         A_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (!div_diff[W]) begin
               mp_in = div_diff[W-1:0];
            end else begin
               mp_in = div_sh[W-1:0];
            end
            my_in  = {my_ff[W-2:0], ~div_diff[W]};
            cnt_in = cnt_ff + CW'(1);
            if (last_step) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            res_in   = neg_ff ? (W'(0) - fix_val) : fix_val;
            state_in = A_DONE;
         end
         A_PCHK: begin
            mp_in  = '0;
            cnt_in = '0;
            if (pex_ff == '0) begin
               res_in   = pacc_ff;
               state_in = A_DONE;
            end else if (pex_ff[0]) begin
               mx_in    = pacc_ff;
               my_in    = psq_ff;
               state_in = A_PMUL;
            end else begin
               pex_in   = pex_sh;
               mx_in    = psq_ff;
               my_in    = psq_ff;
               state_in = A_PSQ;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mp_ff   <= mp_in;
      pacc_ff <= pacc_in;
      psq_ff  <= psq_in;
      pex_ff  <= pex_in;
      res_ff  <= res_in;
      cy_ff   <= cy_in;
      neg_ff  <= neg_in;
      rsel_ff <= rsel_in;
   end

   assign rsp.done   = (state_ff == A_DONE);
   assign rsp.result = res_ff;

endmodule

FILE: src/postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps
//
// Channel  Dir  Ports                                Contents
// req      in   req_tvalid/tready/tdata/tuser/tlast  one postfix token
// rsp      out  rsp_tvalid/tready/tdata/tlast        top of stack, depth, status
//
// A push, or a token rejected for underflow, overflow, divide by zero or an
// unused operator code, goes from the idle state to the final state, where it
// is loaded into the result register once that register is free. Add,
// subtract and multiply run through the 32 one-bit steps of the iterative
// arithmetic unit; divide and remainder add a sign fix-up step. Power handles
// each exponent bit with a check, a 32-step multiply when the bit is set and
// a 32-step square while higher bits remain. Reset is synchronous and active
// high; it empties the stack at once, and the stack memory itself is never
// cleared. One token is in work at a time; while a response waits in the
// output register, the next token is held in its final step until that
// response is taken.

module postfix_stack_evaluator_unit #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata, low bit up: operand_value[31:0], operator_code[34:32], zero pad
   input  logic [psev_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: action (0 push operand, 1 apply operator)
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata, low bit up: top_value[31:0], stack_depth[39:32],
   // status[41:40], zero pad
   output logic [psev_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int W = psev_pkg::DATA_W;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
   localparam int PAD_W = psev_pkg::RSP_DATA_W - W - 8 - 2;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_EXEC = 5'b00100,
      S_WAIT = 5'b01000,
      S_FIN  = 5'b10000
   } main_state_type;

   // The top entry lives in top_ff; entries below it live in the memory at
   // their own stack index.
   main_state_type state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [W-1:0]   top_ff, top_in;
   logic [W-1:0]   val_ff, val_in;
   logic [2:0]     opc_ff, opc_in;
   logic           last_ff, last_in;
   logic [1:0]     status_ff, status_in;
   logic           push_ok_ff, push_ok_in;
   logic           apply_ff, apply_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [psev_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic           rsp_last_ff, rsp_last_in;

   logic [W-1:0]   req_value;
   logic [2:0]     req_opcode;
   logic [SPW-1:0] sp_m1;
   logic [SPW-1:0] sp_m2;
   logic [SPW-1:0] new_sp;
   logic [W-1:0]   new_top;
   logic [W-1:0]   out_top;
   logic           out_free;

   logic           ram_wr_en;
   logic           ram_rd_en;
   logic [W-1:0]   ram_rd_data;

   psev_pkg::alu_ctl_type alu_ctl;
   psev_pkg::alu_rsp_type alu_rsp;

   assign req_value  = req_tdata[W-1:0];
   assign req_opcode = req_tdata[W+2:W];
   assign sp_m1      = sp_ff - SPW'(1);
   assign sp_m2      = sp_ff - SPW'(2);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Stack after the token, before a last token empties it.
   always_comb begin
      if (push_ok_ff) begin
         new_sp  = sp_ff + SPW'(1);
         new_top = val_ff;
      end else if (apply_ff) begin
         new_sp  = sp_m1;
         new_top = alu_rsp.result;
      end else begin
         new_sp  = sp_ff;
         new_top = top_ff;
      end
      out_top = (new_sp == '0) ? '0 : new_top;
   end

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      top_in       = top_ff;
      val_in       = val_ff;
      opc_in       = opc_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      push_ok_in   = push_ok_ff;
      apply_in     = apply_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      alu_ctl.start = 1'b0;
      alu_ctl.op    = opc_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               val_in     = req_value;
               opc_in     = req_opcode;
               last_in    = req_tlast;
               status_in  = psev_pkg::ST_OK;
               push_ok_in = 1'b0;
               apply_in   = 1'b0;
               state_in   = S_FIN;
               if (!req_tuser) begin
                  if (sp_ff == SP_FULL) begin
                     status_in = psev_pkg::ST_OVER;
                  end else begin
                     push_ok_in = 1'b1;
                  end
               end else if (sp_ff < SPW'(2)) begin
                  status_in = psev_pkg::ST_UNDER;
               end else if (req_opcode > psev_pkg::OP_POW) begin
                  // Unused operator codes leave the stack as it is.
                  status_in = psev_pkg::ST_OK;
               end else if ((req_opcode == psev_pkg::OP_DIV ||
                             req_opcode == psev_pkg::OP_REM) && top_ff == '0) begin
                  status_in = psev_pkg::ST_DIVZ;
               end else begin
                  apply_in = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // Fetch the entry below the top.
            ram_rd_en = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            alu_ctl.start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (alu_rsp.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, status_ff, 8'(new_sp), out_top};
               rsp_last_in  = last_ff;
               sp_in        = last_ff ? '0 : new_sp;
               top_in       = new_top;
               // The old top moves down into the memory on a push.
               ram_wr_en    = push_ok_ff && (sp_ff != '0);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         push_ok_ff   <= 1'b0;
         apply_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         push_ok_ff   <= push_ok_in;
         apply_ff     <= apply_in;
      end
      top_ff      <= top_in;
      val_ff      <= val_in;
      opc_ff      <= opc_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   psev_ram #(
      .WIDTH (W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (sp_m1[AW-1:0]),
      .wr_data (top_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (sp_m2[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   psev_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .a     (top_ff),
      .b     (ram_rd_data),
      .rsp   (alu_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: src/psev_chk.sv
`timescale 1ns / 1ps

module psev_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [psev_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                            req_tuser,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [psev_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // A stalled response keeps its contents.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && !reset) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("response changed while stalled");

   // Reset leaves the block ready for a request with no response pending.
   a_reset_idle : assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // Only one token is in work at a time.
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !reset) |=> !req_tready)
      else $error("request taken while a token is in work");

   // An underflow only happens with fewer than two entries held.
   a_underflow_depth : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[41:40] == psev_pkg::ST_UNDER) |->
         (rsp_tdata[39:32] < 8'd2))
      else $error("underflow reported with two or more entries");

endmodule

bind postfix_stack_evaluator_unit psev_chk u_psev_chk (.*);
